FILE: hw/rtl/fat12_sector_address_walker_core_macros.svh
// Assertion macros shared by the FAT12 sector address walker RTL.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef FAT12_SECTOR_ADDRESS_WALKER_CORE_MACROS_SVH
`define FAT12_SECTOR_ADDRESS_WALKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge, ignored while reset is asserted.
`define FSAW_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fat12 walker assertion failed");

// Checked on every rising clock edge, reset included.
`define FSAW_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("fat12 walker assertion failed");

`else

`define FSAW_ASSERT(label, prop)
`define FSAW_ASSERT_ALWAYS(label, prop)

`endif

`endif

FILE: hw/rtl/fsaw_pkg.sv
// Types and constants of the FAT12 sector address walker.
// Depends on nothing; used by fat12_sector_address_walker_core.
package fsaw_pkg;

    // Operation codes of one transfer.
    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD    = 2'd0;
    localparam t_op OP_START   = 2'd1;
    localparam t_op OP_ADVANCE = 2'd2;

    // Configuration register indexes.
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SPC = 1'b0;
    localparam t_cfg_idx CFG_DSS = 1'b1;
    localparam int unsigned CFG_DATA_W = 16;

    // Field widths.
    localparam int unsigned TIDX_W  = 13;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned OFF_W   = 7;
    localparam int unsigned SPC_W   = 8;
    localparam int unsigned ENTRY_W = 12;
    // Byte position of a table entry: (cluster * 3) / 2 of a 16-bit cluster.
    localparam int unsigned POS_W   = 17;

    typedef logic [UNIT_W-1:0]  t_unit;
    typedef logic [OFF_W-1:0]   t_off;
    typedef logic [SPC_W-1:0]   t_spc;
    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [POS_W-1:0]   t_pos;

    // FAT12 entry decoding.
    localparam logic [15:0] ENTRY_MASK   = 16'h0FFF;
    localparam int unsigned ODD_SHIFT    = 4;
    localparam t_unit       END_OF_CHAIN = 16'h0FF8;
    localparam t_spc        SPC_MAX      = 8'd128;

endpackage

FILE: hw/rtl/fat12_sector_address_walker_core.sv
// FAT12 sector address walker: allocation table memory and chain walk sequencer.
// Depends on fsaw_pkg and fat12_sector_address_walker_core_macros.svh.
//
//  channel  | signals                                      | flow
//  ---------+----------------------------------------------+--------------------
//  command  | start, busy, i_op, i_table_index, i_table_byte, | in, taken on start
//           | i_start_value, i_linear_mode                  |   while busy is low
//  result   | o_valid, o_sector_address, o_cluster_now,     | out, one cycle each
//           | o_sector_in_cluster, o_status                 |
//  config   | i_cfg_we, i_cfg_index, i_cfg_data             | in, write only
//
// Loads, linear steps, starts that end the chain and advances of an ended chain
// show their result in the cycle after the transfer, busy stays low.
// A chain start or an advance inside a cluster passes through a multiply state
// and an add state before the result. An advance that crosses a cluster
// boundary first makes two reads of the single table memory port. When
// the entry it reads ends the chain, the result follows the reads and skips the multiply and add states.
// The table memory needs no clearing after reset; reset acts only on the walker
// state and configuration registers. The receiver cannot stall, so a result is never held back.
`include "fat12_sector_address_walker_core_macros.svh"

module fat12_sector_address_walker_core #(
    parameter int unsigned TABLE_BYTES = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  fsaw_pkg::t_op                       i_op,
    input  logic [fsaw_pkg::TIDX_W-1:0]         i_table_index,
    input  logic [7:0]                          i_table_byte,
    input  fsaw_pkg::t_unit                     i_start_value,
    input  logic                                i_linear_mode,
    input  logic                                i_cfg_we,
    input  fsaw_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [fsaw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    output fsaw_pkg::t_unit                     o_sector_address,
    output fsaw_pkg::t_unit                     o_cluster_now,
    output fsaw_pkg::t_off                      o_sector_in_cluster,
    output logic                                o_status
);

    localparam int unsigned AW = $clog2(TABLE_BYTES);
    localparam fsaw_pkg::t_pos TABLE_END = fsaw_pkg::POS_W'(TABLE_BYTES);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;

    // Allocation table and its read register.
    logic [7:0]            r_mem [TABLE_BYTES];
    logic [7:0]            r_rd_data;

    logic [2:0]            r_state, n_state;
    fsaw_pkg::t_unit       r_unit, n_unit;
    fsaw_pkg::t_off        r_offset, n_offset;
    logic                  r_contig, n_contig;
    logic                  r_ended, n_ended;
    fsaw_pkg::t_spc        r_spc;
    fsaw_pkg::t_unit       r_dss;
    logic                  r_odd, n_odd;
    fsaw_pkg::t_pos        r_pos1, n_pos1;
    logic                  r_lo_zero, n_lo_zero;
    logic                  r_hi_zero, n_hi_zero;
    logic [7:0]            r_lo_byte, n_lo_byte;
    fsaw_pkg::t_unit       r_prod, n_prod;
    logic                  r_valid, n_valid;
    fsaw_pkg::t_unit       r_sec, n_sec;
    fsaw_pkg::t_unit       r_clu, n_clu;
    fsaw_pkg::t_off        r_sic, n_sic;
    logic                  r_stat, n_stat;

    logic                  w_mem_we;
    logic                  w_mem_re;
    logic [AW-1:0]         w_ra;
    fsaw_pkg::t_spc        w_spc_eff;
    logic [fsaw_pkg::SPC_W-1:0] w_off_inc;
    logic [fsaw_pkg::POS_W:0]   w_pos3;
    fsaw_pkg::t_pos        w_pos;
    fsaw_pkg::t_unit       w_rel;
    logic [23:0]           w_prod;
    logic [15:0]           w_word;
    fsaw_pkg::t_entry      w_entry;
    logic [7:0]            w_hi_byte;
    fsaw_pkg::t_unit       w_unit_inc;

    // Effective sectors per cluster: zero acts as one, above the maximum clamps.
    always_comb begin
        if (r_spc == '0) begin
            w_spc_eff = fsaw_pkg::t_spc'(1);
        end else if (r_spc > fsaw_pkg::SPC_MAX) begin
            w_spc_eff = fsaw_pkg::SPC_MAX;
        end else begin
            w_spc_eff = r_spc;
        end
    end

    // Datapath pieces shared by the sequencer.
    assign w_off_inc  = {1'b0, r_offset} + fsaw_pkg::SPC_W'(1);
    assign w_pos3     = {2'b00, r_unit} + {1'b0, r_unit, 1'b0};
    assign w_pos      = w_pos3[fsaw_pkg::POS_W:1];
    assign w_rel      = r_unit - fsaw_pkg::UNIT_W'(2);
    assign w_prod     = {8'd0, w_rel} * {16'd0, w_spc_eff};
    assign w_unit_inc = r_unit + fsaw_pkg::UNIT_W'(1);
    assign w_hi_byte  = r_hi_zero ? 8'd0 : r_rd_data;
    assign w_word     = {w_hi_byte, r_lo_byte};

    // Even clusters take the low 12 bits, odd ones the word shifted down.
    always_comb begin
        if (r_odd) begin
            w_entry = fsaw_pkg::ENTRY_W'(w_word >> fsaw_pkg::ODD_SHIFT);
        end else begin
            w_entry = fsaw_pkg::ENTRY_W'(w_word & fsaw_pkg::ENTRY_MASK);
        end
    end

    // Sequencer and next state of the walker.
    always_comb begin
        n_state   = r_state;
        n_unit    = r_unit;
        n_offset  = r_offset;
        n_contig  = r_contig;
        n_ended   = r_ended;
        n_odd     = r_odd;
        n_pos1    = r_pos1;
        n_lo_zero = r_lo_zero;
        n_hi_zero = r_hi_zero;
        n_lo_byte = r_lo_byte;
        n_prod    = r_prod;
        n_valid   = 1'b0;
        n_sec     = r_sec;
        n_clu     = r_clu;
        n_sic     = r_sic;
        n_stat    = r_stat;
        w_mem_we  = 1'b0;
        w_mem_re  = 1'b0;
        w_ra      = w_pos[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        fsaw_pkg::OP_START: begin
                            n_unit   = i_start_value;
                            n_offset = '0;
                            n_contig = i_linear_mode;
                            n_ended  = 1'b0;
                            if (i_linear_mode) begin
                                n_valid = 1'b1;
                                n_sec   = i_start_value;
                                n_clu   = i_start_value;
                                n_sic   = '0;
                                n_stat  = 1'b0;
                            end else if (i_start_value >= fsaw_pkg::END_OF_CHAIN) begin
                                n_ended = 1'b1;
                                n_valid = 1'b1;
                                n_sec   = '0;
                                n_clu   = i_start_value;
                                n_sic   = '0;
                                n_stat  = 1'b1;
                            end else begin
                                n_state = S_MUL;
                            end
                        end
                        fsaw_pkg::OP_ADVANCE: begin
                            if (r_ended) begin
                                n_valid = 1'b1;
                                n_sec   = '0;
                                n_clu   = r_unit;
                                n_sic   = r_offset;
                                n_stat  = 1'b1;
                            end else if (r_contig) begin
                                n_unit  = w_unit_inc;
                                n_valid = 1'b1;
                                n_sec   = w_unit_inc;
                                n_clu   = w_unit_inc;
                                n_sic   = r_offset;
                                n_stat  = 1'b0;
                            end else if (w_off_inc >= w_spc_eff) begin
                                // Cluster boundary: fetch the low entry byte.
                                n_offset  = '0;
                                n_odd     = r_unit[0];
                                w_mem_re  = (w_pos < TABLE_END);
                                n_lo_zero = !(w_pos < TABLE_END);
                                n_pos1    = w_pos + fsaw_pkg::POS_W'(1);
                                n_state   = S_RD0;
                            end else begin
                                n_offset = w_off_inc[fsaw_pkg::OFF_W-1:0];
                                n_state  = S_MUL;
                            end
                        end
                        default: begin
                            // A load writes in-range bytes; unused codes change nothing.
                            w_mem_we = (i_op == fsaw_pkg::OP_LOAD) &&
                                       ({4'd0, i_table_index} < TABLE_END);
                            n_valid  = 1'b1;
                            n_sec    = '0;
                            n_clu    = r_unit;
                            n_sic    = r_offset;
                            n_stat   = r_ended;
                        end
                    endcase
                end
            end
            S_RD0: begin
                // Low byte is back; fetch the high byte.
                n_lo_byte = r_lo_zero ? 8'd0 : r_rd_data;
                w_ra      = r_pos1[AW-1:0];
                w_mem_re  = (r_pos1 < TABLE_END);
                n_hi_zero = !(r_pos1 < TABLE_END);
                n_state   = S_RD1;
            end
            S_RD1: begin
                n_unit = {4'd0, w_entry};
                if ({4'd0, w_entry} >= fsaw_pkg::END_OF_CHAIN) begin
                    n_ended = 1'b1;
                    n_valid = 1'b1;
                    n_sec   = '0;
                    n_clu   = {4'd0, w_entry};
                    n_sic   = r_offset;
                    n_stat  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = w_prod[fsaw_pkg::UNIT_W-1:0];
                n_state = S_ADD;
            end
            S_ADD: begin
                n_valid = 1'b1;
                n_sec   = r_dss + r_prod + {9'd0, r_offset};
                n_clu   = r_unit;
                n_sic   = r_offset;
                n_stat  = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table memory: one write or one read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[AW'(i_table_index)] <= i_table_byte;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_unit   <= '0;
            r_offset <= '0;
            r_contig <= 1'b0;
            r_ended  <= 1'b0;
            r_valid  <= 1'b0;
            r_spc    <= fsaw_pkg::t_spc'(1);
            r_dss    <= '0;
        end else begin
            r_state  <= n_state;
            r_unit   <= n_unit;
            r_offset <= n_offset;
            r_contig <= n_contig;
            r_ended  <= n_ended;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fsaw_pkg::CFG_SPC: r_spc <= i_cfg_data[fsaw_pkg::SPC_W-1:0];
                    fsaw_pkg::CFG_DSS: r_dss <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_odd     <= n_odd;
        r_pos1    <= n_pos1;
        r_lo_zero <= n_lo_zero;
        r_hi_zero <= n_hi_zero;
        r_lo_byte <= n_lo_byte;
        r_prod    <= n_prod;
        r_sec     <= n_sec;
        r_clu     <= n_clu;
        r_sic     <= n_sic;
        r_stat    <= n_stat;
    end

    assign busy                = (r_state != S_IDLE);
    assign o_valid             = r_valid;
    assign o_sector_address    = r_sec;
    assign o_cluster_now       = r_clu;
    assign o_sector_in_cluster = r_sic;
    assign o_status            = r_stat;

    // A result only appears once the sequencer is back at rest.
    `FSAW_ASSERT(a_valid_when_idle, o_valid |-> !busy)
    // An ended chain never reports a sector address.
    `FSAW_ASSERT(a_ended_zero_addr, (o_valid && o_status) |-> (o_sector_address == '0))
    // A load transfer is answered in the next cycle.
    `FSAW_ASSERT(a_load_answers, (start && !busy && (i_op == fsaw_pkg::OP_LOAD)) |=> o_valid)
    // The two table reads of a lookup run back to back.
    `FSAW_ASSERT(a_rd0_to_rd1, (r_state == S_RD0) |=> (r_state == S_RD1))

endmodule

FILE: sim/fat12_sector_address_walker_core_tb.sv
// Self-checking testbench for fat12_sector_address_walker_core.
// Depends on fsaw_pkg and the core RTL. Commands are checked against an
// in-bench model of the table walk.
`timescale 1ns / 100ps

module fat12_sector_address_walker_core_tb;

    localparam int unsigned TABLE_BYTES  = 8192;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 250;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned MAX_ADVANCES = 260;
    localparam fsaw_pkg::t_op  OP_UNUSED = 2'd3;
    localparam fsaw_pkg::t_spc SPC_PLAN [PHASES] = '{8'd1, 8'd0, 8'd2, 8'd128,
                                                     8'd3, 8'd255, 8'd4, 8'd1};
    localparam fsaw_pkg::t_unit DSS_PLAN [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFE};

    // One result as it leaves the block.
    typedef struct packed {
        fsaw_pkg::t_unit sector;
        fsaw_pkg::t_unit cluster;
        fsaw_pkg::t_off  sec_idx;
        logic            status;
    } t_walk_result;

    // One command transfer, with an optional hand-written expectation.
    typedef struct {
        fsaw_pkg::t_op               op;
        logic [fsaw_pkg::TIDX_W-1:0] tidx;
        logic [7:0]                  tbyte;
        fsaw_pkg::t_unit             sval;
        logic                        lin;
        bit                          typed;
        t_walk_result                res;
    } t_walk_cmd;

    // Block ports.
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    fsaw_pkg::t_op                   i_op = fsaw_pkg::OP_LOAD;
    logic [fsaw_pkg::TIDX_W-1:0]     i_table_index = '0;
    logic [7:0]                      i_table_byte = '0;
    fsaw_pkg::t_unit                 i_start_value = '0;
    logic                            i_linear_mode = 1'b0;
    logic                            i_cfg_we = 1'b0;
    fsaw_pkg::t_cfg_idx              i_cfg_index = fsaw_pkg::CFG_SPC;
    logic [fsaw_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            o_valid;
    fsaw_pkg::t_unit                 o_sector_address;
    fsaw_pkg::t_unit                 o_cluster_now;
    fsaw_pkg::t_off                  o_sector_in_cluster;
    logic                            o_status;

    // Mirror of the walker state and configuration.
    logic [7:0]         walk_tbl [TABLE_BYTES];
    bit                 tbl_loaded [TABLE_BYTES];
    fsaw_pkg::t_unit    walk_cluster = '0;
    fsaw_pkg::t_off     walk_off = '0;
    logic               walk_linear = 1'b0;
    logic               walk_ended = 1'b0;
    fsaw_pkg::t_spc     reg_spc = 8'd1;
    fsaw_pkg::t_unit    reg_dss = '0;

    t_walk_result       pending_results [$];
    t_walk_cmd          dir_rows [$];
    int unsigned        fail_count = 0;
    int unsigned        items_sent = 0;
    int unsigned        stall_cycles = 0;
    bit                 no_idle = 1'b0;

    fat12_sector_address_walker_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_table_index      (i_table_index),
        .i_table_byte       (i_table_byte),
        .i_start_value      (i_start_value),
        .i_linear_mode      (i_linear_mode),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_sector_address   (o_sector_address),
        .o_cluster_now      (o_cluster_now),
        .o_sector_in_cluster(o_sector_in_cluster),
        .o_status           (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Sectors per cluster as the walker uses them: zero acts as one, and the
    // count saturates at the largest cluster size.
    function automatic int unsigned spc_in_use();
        if (reg_spc == 8'd0) return 1;
        if (reg_spc > fsaw_pkg::SPC_MAX) return fsaw_pkg::SPC_MAX;
        return reg_spc;
    endfunction

    function automatic int unsigned tbl_byte(int unsigned idx);
        return (idx < TABLE_BYTES) ? walk_tbl[idx] : 0;
    endfunction

    // Data area sector of a cluster, wrapped to 16 bits.
    function automatic int unsigned cluster_to_sector(int unsigned cl, int unsigned off);
        int unsigned rel;
        rel = (cl - 2) & 32'hFFFF;
        return (reg_dss + rel * spc_in_use() + off) & 32'hFFFF;
    endfunction

    // Applies one command to the mirror state and returns the result it yields.
    function automatic t_walk_result walk_predict(t_walk_cmd c);
        t_walk_result r;
        int unsigned  sector, off, cl, pos, word;
        sector = 0;
        case (c.op)
            fsaw_pkg::OP_LOAD: begin
                if (c.tidx < TABLE_BYTES) begin
                    walk_tbl[c.tidx] = c.tbyte;
                    tbl_loaded[c.tidx] = 1'b1;
                end
            end
            fsaw_pkg::OP_START: begin
                walk_cluster = c.sval;
                walk_off = '0;
                walk_linear = c.lin;
                walk_ended = 1'b0;
                if (c.lin) sector = c.sval;
                else if (c.sval >= fsaw_pkg::END_OF_CHAIN) walk_ended = 1'b1;
                else sector = cluster_to_sector(c.sval, 0);
            end
            fsaw_pkg::OP_ADVANCE: begin
                if (walk_ended) begin
                    sector = 0;
                end else if (walk_linear) begin
                    walk_cluster = walk_cluster + 16'd1;
                    sector = walk_cluster;
                end else begin
                    off = walk_off + 1;
                    cl = walk_cluster;
                    // Passing the last sector of a cluster follows the 12-bit entry.
                    if (off >= spc_in_use()) begin
                        off = 0;
                        pos = cl * 3 / 2;
                        word = tbl_byte(pos) | (tbl_byte(pos + 1) << 8);
                        cl = cl[0] ? (word >> fsaw_pkg::ODD_SHIFT)
                                   : (word & fsaw_pkg::ENTRY_MASK);
                    end
                    walk_cluster = cl[15:0];
                    walk_off = off[fsaw_pkg::OFF_W-1:0];
                    if (cl >= fsaw_pkg::END_OF_CHAIN) walk_ended = 1'b1;
                    else sector = cluster_to_sector(cl, off);
                end
            end
            default: ;
        endcase
        if (walk_ended) sector = 0;
        r.sector = sector[15:0];
        r.cluster = walk_cluster;
        r.sec_idx = walk_off;
        r.status = walk_ended;
        return r;
    endfunction

    function automatic t_walk_cmd mk_cmd(fsaw_pkg::t_op op,
                                         logic [fsaw_pkg::TIDX_W-1:0] tidx,
                                         logic [7:0] tbyte, fsaw_pkg::t_unit sval,
                                         logic lin);
        t_walk_cmd c;
        c.op = op;
        c.tidx = tidx;
        c.tbyte = tbyte;
        c.sval = sval;
        c.lin = lin;
        c.typed = 1'b0;
        c.res = '0;
        return c;
    endfunction

    function automatic t_walk_cmd typed_row(t_walk_cmd c, fsaw_pkg::t_unit sector,
                                            fsaw_pkg::t_unit cluster,
                                            fsaw_pkg::t_off sec_idx, logic status);
        c.typed = 1'b1;
        c.res = '{sector, cluster, sec_idx, status};
        return c;
    endfunction

    // Drives one command, waits for its transfer and queues its expected result.
    task automatic send_cmd(t_walk_cmd c);
        t_walk_result pred;
        int unsigned  gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= c.op;
        i_table_index <= c.tidx;
        i_table_byte <= c.tbyte;
        i_start_value <= c.sval;
        i_linear_mode <= c.lin;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pred = walk_predict(c);
        pending_results.push_back(c.typed ? c.res : pred);
        items_sent++;
    endtask

    task automatic send_load(int unsigned idx, logic [7:0] value);
        send_cmd(mk_cmd(fsaw_pkg::OP_LOAD, idx[fsaw_pkg::TIDX_W-1:0], value,
                        16'($urandom), 1'($urandom)));
    endtask

    // An advance that will cross a cluster boundary first gets any table byte
    // it reads loaded, so no never-written entry is ever looked up.
    task automatic send_advance();
        int unsigned pos;
        if (!walk_ended && !walk_linear && (walk_off + 1 >= spc_in_use())) begin
            pos = walk_cluster * 3 / 2;
            for (int k = 0; k < 2; k++)
                if (!tbl_loaded[pos + k]) send_load(pos + k, 8'($urandom));
        end
        send_cmd(mk_cmd(fsaw_pkg::OP_ADVANCE, 13'($urandom), 8'($urandom), 16'($urandom),
                        1'($urandom)));
    endtask

    // Writes a 12-bit entry, keeping the nibble shared with the neighbor entry.
    task automatic set_entry(int unsigned cl, int unsigned val);
        int unsigned pos;
        logic [7:0]  lo, hi;
        pos = cl * 3 / 2;
        if (cl[0]) begin
            lo = {val[3:0], walk_tbl[pos][3:0]};
            hi = val[11:4];
        end else begin
            lo = val[7:0];
            hi = {walk_tbl[pos + 1][7:4], val[11:8]};
        end
        send_load(pos, lo);
        send_load(pos + 1, hi);
    endtask

    // Builds a short chain in the table, starts on it and walks it.
    task automatic walk_chain();
        int unsigned len, head, cl, nxt, n_adv;
        len = (spc_in_use() > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        head = $urandom_range(0, 'hFF7);
        cl = head;
        for (int k = 0; k < len; k++) begin
            if (k == len - 1)
                nxt = ($urandom_range(0, 2) != 0) ? 'hFF8 + $urandom_range(0, 7)
                                                  : $urandom_range(0, 'hFFF);
            else
                nxt = $urandom_range(0, 'hFF7);
            set_entry(cl, nxt);
            cl = nxt;
        end
        send_cmd(mk_cmd(fsaw_pkg::OP_START, 13'($urandom), 8'($urandom), 16'(head), 1'b0));
        n_adv = $urandom_range(1, len * spc_in_use() + 3);
        if (n_adv > MAX_ADVANCES) n_adv = MAX_ADVANCES;
        repeat (n_adv) send_advance();
    endtask

    // Contiguous walk, often near the top of the sector range so it wraps.
    task automatic walk_contiguous();
        fsaw_pkg::t_unit first;
        first = $urandom_range(0, 1) ? 16'($urandom) : 16'hFFFF - 16'($urandom_range(0, 6));
        send_cmd(mk_cmd(fsaw_pkg::OP_START, 13'($urandom), 8'($urandom), first, 1'b1));
        repeat ($urandom_range(1, 10)) send_advance();
    endtask

    // Random commands of every kind, with fully random fields.
    task automatic send_noise();
        fsaw_pkg::t_op op;
        repeat ($urandom_range(1, 8)) begin
            op = fsaw_pkg::t_op'($urandom_range(0, 3));
            if (op == fsaw_pkg::OP_ADVANCE) send_advance();
            else send_cmd(mk_cmd(op, 13'($urandom), 8'($urandom), 16'($urandom),
                                 1'($urandom)));
        end
    endtask

    // Lets every outstanding result arrive before configuration changes.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the caller drops the write enable after its last write.
    task automatic write_cfg(fsaw_pkg::t_cfg_idx idx,
                             logic [fsaw_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == fsaw_pkg::CFG_SPC) reg_spc = data[fsaw_pkg::SPC_W-1:0];
        else reg_dss = data;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result checker: every strobed result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_walk_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual %h %h %h %b",
                         $time, o_sector_address, o_cluster_now, o_sector_in_cluster,
                         o_status);
            end else begin
                want = pending_results.pop_front();
                check_field("sector_address", want.sector, o_sector_address);
                check_field("cluster_now", want.cluster, o_cluster_now);
                check_field("sector_in_cluster", want.sec_idx, o_sector_in_cluster);
                check_field("status", want.status, o_status);
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus: directed table first, then random phases under several settings.
    initial begin
        int unsigned     phase_end, pick;
        fsaw_pkg::t_spc  spc_val;
        fsaw_pkg::t_unit dss_val;

        foreach (walk_tbl[i]) begin
            walk_tbl[i] = 8'h00;
            tbl_loaded[i] = 1'b0;
        end

        // Directed rows run with the reset settings: one sector per cluster,
        // data area at sector zero. The table holds cluster 0 -> 3 -> end and
        // cluster 1 -> 5.
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_LOAD, 13'd0, 8'h03, 16'h0, 1'b0),
                                     0, 0, 0, 0));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_LOAD, 13'd1, 8'h50, 16'h0, 1'b0),
                                     0, 0, 0, 0));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_LOAD, 13'd2, 8'h00, 16'h0, 1'b0),
                                     0, 0, 0, 0));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_LOAD, 13'd4, 8'hF0, 16'h0, 1'b0),
                                     0, 0, 0, 0));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_LOAD, 13'd5, 8'hFF, 16'h0, 1'b0),
                                     0, 0, 0, 0));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_LOAD, 13'h1FFF, 8'hFF, 16'hFFFF,
                                            1'b1), 0, 0, 0, 0));
        // The unused code changes nothing and reports like a load.
        dir_rows.push_back(typed_row(mk_cmd(OP_UNUSED, 13'd0, 8'hAA, 16'h1234, 1'b1),
                                     0, 0, 0, 0));
        // Contiguous walk from the top sector wraps to zero.
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_START, 13'd0, 8'h00, 16'hFFFF,
                                            1'b1), 16'hFFFF, 16'hFFFF, 0, 0));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_ADVANCE, 13'd0, 8'h00, 16'h0,
                                            1'b0), 0, 0, 0, 0));
        // A start at the end-of-chain marker ends at once, and stays ended.
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_START, 13'd0, 8'h00, 16'h0FF8,
                                            1'b0), 0, 16'h0FF8, 0, 1));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_ADVANCE, 13'd0, 8'h00, 16'h0,
                                            1'b0), 0, 16'h0FF8, 0, 1));
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_START, 13'd0, 8'h00, 16'hFFFF,
                                            1'b0), 0, 16'hFFFF, 0, 1));
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_START, 13'd0, 8'h00, 16'h0FF7, 1'b0));
        // Cluster zero lies below the data area, so its sector wraps.
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_START, 13'd0, 8'h00, 16'h0000, 1'b0));
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_ADVANCE, 13'd0, 8'h00, 16'h0, 1'b0));
        // Odd cluster 3 holds 0xFFF: the chain ends.
        dir_rows.push_back(typed_row(mk_cmd(fsaw_pkg::OP_ADVANCE, 13'd0, 8'h00, 16'h0,
                                            1'b0), 0, 16'h0FFF, 0, 1));
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_START, 13'd0, 8'h00, 16'h0001, 1'b0));
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_ADVANCE, 13'h1FFF, 8'hFF, 16'hFFFF, 1'b1));
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_START, 13'd0, 8'h00, 16'h1234, 1'b1));
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_ADVANCE, 13'd0, 8'h00, 16'h0, 1'b0));
        dir_rows.push_back(mk_cmd(fsaw_pkg::OP_LOAD, 13'h1FFF, 8'h00, 16'hFFFF, 1'b1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_cmd(dir_rows[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            spc_val = (ph == PHASES - 1) ? 8'($urandom_range(1, 8)) : SPC_PLAN[ph];
            dss_val = ph[0] ? 16'($urandom) : DSS_PLAN[ph >> 1];
            write_cfg(fsaw_pkg::CFG_SPC, {8'($urandom), spc_val});
            write_cfg(fsaw_pkg::CFG_DSS, dss_val);
            i_cfg_we <= 1'b0;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                no_idle = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 55) walk_chain();
                else if (pick < 70) walk_contiguous();
                else send_noise();
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/fsaw_pkg.sv
hw/rtl/fat12_sector_address_walker_core.sv
sim/fat12_sector_address_walker_core_tb.sv
